>>> hdl/ptmdg_pkg.sv
`timescale 1ns / 1ps

package ptmdg_pkg;

	localparam int COEF_BITS = 16;
	localparam int FRAC_BITS = 14;
	localparam int GAIN_FRAC = 12;
	localparam int GAIN_BITS = 16;
	localparam int DIR_BITS  = 16;
	localparam int BYTE_BITS = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam int GAIN_ONE = 1 << GAIN_FRAC;
	localparam int BYTE_MAX = (1 << BYTE_BITS) - 1;
	localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(8192);

	localparam int PIPE_STAGES = 9;

	localparam int K_W     = GAIN_BITS + 1;
	localparam int GS_W    = GAIN_BITS + 1;
	localparam int CN_W    = COEF_BITS + DIR_BITS;
	localparam int LIN_W   = CN_W + 2;
	localparam int KL_W    = K_W + LIN_W;
	localparam int KLSH_W  = KL_W - GAIN_FRAC;
	localparam int A_W     = KLSH_W + 1;
	localparam int CNN_W   = CN_W + DIR_BITS;
	localparam int QS_W    = CNN_W + 2;
	localparam int S_W     = QS_W - FRAC_BITS;
	localparam int KS_W    = K_W + S_W;
	localparam int KSSH_W  = KS_W - GAIN_FRAC;
	localparam int D_W     = A_W + 1;
	localparam int DN_W    = D_W + DIR_BITS;
	localparam int DNSH_W  = DN_W - FRAC_BITS;
	localparam int AL_W    = A_W + DIR_BITS;
	localparam int ALSH_W  = AL_W - FRAC_BITS;
	localparam int QG_W    = S_W + GS_W;
	localparam int QGSH_W  = QG_W - GAIN_FRAC;
	localparam int A5_W    = ((KSSH_W > DNSH_W) ? KSSH_W : DNSH_W) + 2;
	localparam int P_W     = ((QGSH_W > ALSH_W) ? QGSH_W : ALSH_W) + 2;
	localparam int T_W     = ((A5_W > P_W) ? A5_W : P_W) + 1;
	localparam int TSH_W   = T_W - FRAC_BITS;
	localparam int XT_W    = T_W + BYTE_BITS + 1;
	localparam int XTSH_W  = XT_W - FRAC_BITS - BYTE_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN    = 2'd0,
		REG_LIGHT_U = 2'd1,
		REG_LIGHT_V = 2'd2
	} cfg_reg_t;

	localparam logic OP_CHANNEL   = 1'b0;
	localparam logic OP_LUMINANCE = 1'b1;

endpackage

>>> hdl/ptm_diffuse_gain_shade.sv
`timescale 1ns / 1ps

// Diffuse gain shading of polynomial texture map pixels. Each request carries
// six biquadratic coefficients, the pixel normal and three colour bytes; the
// block rewrites the coefficients by the diffuse gain rule about the normal,
// evaluates the polynomial at the configured light direction and returns one
// channel byte (opcode 0) or three luminance-scaled colour bytes (opcode 1).
// The datapath is a nine-stage pipeline with one multiply or one wide add per
// stage, so one request is taken every clock while out_stall is low, and the
// result is held in the ninth stage register that drives the outputs. Bubbles
// are squeezed out under stall, so requests keep entering
// while a finished result waits. Gain and light registers are written through
// the cfg port, which is always ready; write them only while the pipeline is
// empty. Writes to an index beyond the light v register are ignored.
module ptm_diffuse_gain_shade (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           cfg_valid,
	output logic                                           cfg_ready,
	input  logic [ptmdg_pkg::CFG_IDX_W-1:0]                cfg_index,
	input  logic [ptmdg_pkg::CFG_DATA_W-1:0]               cfg_data,
	input  logic                                           in_valid,
	output logic                                           in_stall,
	input  logic                                           opcode,
	input  logic signed [ptmdg_pkg::COEF_BITS-1:0]         coef_0,
	input  logic signed [ptmdg_pkg::COEF_BITS-1:0]         coef_1,
	input  logic signed [ptmdg_pkg::COEF_BITS-1:0]         coef_2,
	input  logic signed [ptmdg_pkg::COEF_BITS-1:0]         coef_3,
	input  logic signed [ptmdg_pkg::COEF_BITS-1:0]         coef_4,
	input  logic signed [ptmdg_pkg::COEF_BITS-1:0]         coef_5,
	input  logic signed [ptmdg_pkg::DIR_BITS-1:0]          normal_u,
	input  logic signed [ptmdg_pkg::DIR_BITS-1:0]          normal_v,
	input  logic [ptmdg_pkg::BYTE_BITS-1:0]                red_in,
	input  logic [ptmdg_pkg::BYTE_BITS-1:0]                green_in,
	input  logic [ptmdg_pkg::BYTE_BITS-1:0]                blue_in,
	output logic                                           out_valid,
	input  logic                                           out_stall,
	output logic [ptmdg_pkg::BYTE_BITS-1:0]                out_red,
	output logic [ptmdg_pkg::BYTE_BITS-1:0]                out_green,
	output logic [ptmdg_pkg::BYTE_BITS-1:0]                out_blue
);

	localparam int NS    = ptmdg_pkg::PIPE_STAGES;
	localparam int CB    = ptmdg_pkg::COEF_BITS;
	localparam int FB    = ptmdg_pkg::FRAC_BITS;
	localparam int GF    = ptmdg_pkg::GAIN_FRAC;
	localparam int DB    = ptmdg_pkg::DIR_BITS;
	localparam int BB    = ptmdg_pkg::BYTE_BITS;
	localparam int K_W   = ptmdg_pkg::K_W;
	localparam int GS_W  = ptmdg_pkg::GS_W;
	localparam int CN_W  = ptmdg_pkg::CN_W;
	localparam int LIN_W = ptmdg_pkg::LIN_W;
	localparam int KL_W  = ptmdg_pkg::KL_W;
	localparam int KLSH_W = ptmdg_pkg::KLSH_W;
	localparam int A_W   = ptmdg_pkg::A_W;
	localparam int CNN_W = ptmdg_pkg::CNN_W;
	localparam int QS_W  = ptmdg_pkg::QS_W;
	localparam int S_W   = ptmdg_pkg::S_W;
	localparam int KS_W  = ptmdg_pkg::KS_W;
	localparam int KSSH_W = ptmdg_pkg::KSSH_W;
	localparam int D_W   = ptmdg_pkg::D_W;
	localparam int DN_W  = ptmdg_pkg::DN_W;
	localparam int DNSH_W = ptmdg_pkg::DNSH_W;
	localparam int AL_W  = ptmdg_pkg::AL_W;
	localparam int ALSH_W = ptmdg_pkg::ALSH_W;
	localparam int QG_W  = ptmdg_pkg::QG_W;
	localparam int QGSH_W = ptmdg_pkg::QGSH_W;
	localparam int A5_W  = ptmdg_pkg::A5_W;
	localparam int P_W   = ptmdg_pkg::P_W;
	localparam int T_W   = ptmdg_pkg::T_W;
	localparam int TSH_W = ptmdg_pkg::TSH_W;
	localparam int XT_W  = ptmdg_pkg::XT_W;
	localparam int XTSH_W = ptmdg_pkg::XTSH_W;

	function automatic logic [BB-1:0] sat_byte(input logic signed [XT_W-1:0] v);
		logic [BB-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > XT_W'(ptmdg_pkg::BYTE_MAX)) begin
			r = BB'(ptmdg_pkg::BYTE_MAX);
		end else begin
			r = v[BB-1:0];
		end
		return r;
	endfunction

	// Configuration registers.
	logic [ptmdg_pkg::GAIN_BITS-1:0] gain_q;
	logic signed [K_W-1:0]           k_q;
	logic signed [DB-1:0]            light_u_q;
	logic signed [DB-1:0]            light_v_q;
	logic signed [GS_W-1:0]          gain_s;

	assign cfg_ready = 1'b1;
	assign gain_s = $signed({1'b0, gain_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= ptmdg_pkg::GAIN_RESET;
			k_q       <= K_W'(ptmdg_pkg::GAIN_ONE) - K_W'($signed({1'b0, ptmdg_pkg::GAIN_RESET}));
			light_u_q <= '0;
			light_v_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ptmdg_pkg::REG_GAIN: begin
					gain_q <= cfg_data;
					k_q    <= K_W'(ptmdg_pkg::GAIN_ONE) - K_W'($signed({1'b0, cfg_data}));
				end
				ptmdg_pkg::REG_LIGHT_U: begin
					light_u_q <= $signed(cfg_data);
				end
				ptmdg_pkg::REG_LIGHT_V: begin
					light_v_q <= $signed(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// Pipeline control: a stage loads when it is empty or its content moves on.
	logic [NS:1]   vld_q;
	logic [NS:1]   adv;
	logic [NS-1:0] vld_in;

	assign vld_in = {vld_q[NS-1:1], in_valid};

	always_comb begin
		adv[NS] = !vld_q[NS] || !out_stall;
		for (int i = NS - 1; i >= 1; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign in_stall  = !adv[1];
	assign out_valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NS; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_in[i-1];
				end
			end
		end
	end

	// Stage registers.
	logic          op_s1, op_s2, op_s3, op_s4, op_s5, op_s6, op_s7, op_s8;
	logic [BB-1:0] red_s1, red_s2, red_s3, red_s4, red_s5, red_s6, red_s7;
	logic [BB-1:0] grn_s1, grn_s2, grn_s3, grn_s4, grn_s5, grn_s6, grn_s7;
	logic [BB-1:0] blu_s1, blu_s2, blu_s3, blu_s4, blu_s5, blu_s6, blu_s7;
	logic signed [CB-1:0] c3_s1, c3_s2, c4_s1, c4_s2, c3_s3, c4_s3;
	logic signed [CB-1:0] c5_s1, c5_s2, c5_s3, c5_s4, c5_s5;
	logic signed [DB-1:0] nu_s1, nu_s2, nu_s3, nu_s4;
	logic signed [DB-1:0] nv_s1, nv_s2, nv_s3, nv_s4;

	logic signed [CN_W-1:0]  c0nu_s1, c2nv_s1, c1nv_s1, c2nu_s1, c0lu_s1, c1lv_s1, c2lu_s1;
	logic signed [LIN_W-1:0] lin3_s2, lin4_s2;
	logic signed [CNN_W-1:0] q0n_s2, q1n_s2, q2n_s2, q0l_s2, q1l_s2, q2l_s2;
	logic signed [KL_W-1:0]  kl3_s3, kl4_s3;
	logic signed [S_W-1:0]   s5_s3, ql_s3;
	logic signed [A_W-1:0]   a3_s4, a4_s4;
	logic signed [D_W-1:0]   d3_s4, d4_s4;
	logic signed [KS_W-1:0]  ks5_s4, ks5_s5;
	logic signed [QG_W-1:0]  qg_s4, qg_s5;
	logic signed [DN_W-1:0]  d3n_s5, d4n_s5;
	logic signed [AL_W-1:0]  a3l_s5, a4l_s5;
	logic signed [A5_W-1:0]  a5_s6;
	logic signed [P_W-1:0]   p_s6;
	logic signed [T_W-1:0]   t_s7;
	logic signed [XT_W-1:0]  xr_s8, xg_s8, xb_s8;
	logic [BB-1:0]           ch_s8;
	logic [BB-1:0]           red_s9, grn_s9, blu_s9;

	// Combinational terms between stages.
	logic signed [QS_W-1:0]   qsn, qsl;
	logic signed [KLSH_W-1:0] kl3_sh, kl4_sh;
	logic signed [KSSH_W-1:0] ks5_sh;
	logic signed [DNSH_W-1:0] d3n_sh, d4n_sh;
	logic signed [ALSH_W-1:0] a3l_sh, a4l_sh;
	logic signed [QGSH_W-1:0] qg_sh;
	logic signed [TSH_W-1:0]  t_sh;
	logic signed [XTSH_W-1:0] xr_sh, xg_sh, xb_sh;

	always_comb begin
		qsn    = QS_W'(q0n_s2) + QS_W'(q1n_s2) + QS_W'(q2n_s2);
		qsl    = QS_W'(q0l_s2) + QS_W'(q1l_s2) + QS_W'(q2l_s2);
		kl3_sh = kl3_s3[KL_W-1:GF];
		kl4_sh = kl4_s3[KL_W-1:GF];
		ks5_sh = ks5_s5[KS_W-1:GF];
		d3n_sh = d3n_s5[DN_W-1:FB];
		d4n_sh = d4n_s5[DN_W-1:FB];
		a3l_sh = a3l_s5[AL_W-1:FB];
		a4l_sh = a4l_s5[AL_W-1:FB];
		qg_sh  = qg_s5[QG_W-1:GF];
		t_sh   = t_s7[T_W-1:FB];
		xr_sh  = xr_s8[XT_W-1:FB+BB];
		xg_sh  = xg_s8[XT_W-1:FB+BB];
		xb_sh  = xb_s8[XT_W-1:FB+BB];
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			op_s1   <= opcode;
			red_s1  <= red_in;
			grn_s1  <= green_in;
			blu_s1  <= blue_in;
			c3_s1   <= coef_3;
			c4_s1   <= coef_4;
			c5_s1   <= coef_5;
			nu_s1   <= normal_u;
			nv_s1   <= normal_v;
			c0nu_s1 <= CN_W'(coef_0) * CN_W'(normal_u);
			c2nv_s1 <= CN_W'(coef_2) * CN_W'(normal_v);
			c1nv_s1 <= CN_W'(coef_1) * CN_W'(normal_v);
			c2nu_s1 <= CN_W'(coef_2) * CN_W'(normal_u);
			c0lu_s1 <= CN_W'(coef_0) * CN_W'(light_u_q);
			c1lv_s1 <= CN_W'(coef_1) * CN_W'(light_v_q);
			c2lu_s1 <= CN_W'(coef_2) * CN_W'(light_u_q);
		end
		if (adv[2]) begin
			op_s2   <= op_s1;
			red_s2  <= red_s1;
			grn_s2  <= grn_s1;
			blu_s2  <= blu_s1;
			c3_s2   <= c3_s1;
			c4_s2   <= c4_s1;
			c5_s2   <= c5_s1;
			nu_s2   <= nu_s1;
			nv_s2   <= nv_s1;
			lin3_s2 <= (LIN_W'(c0nu_s1) <<< 1) + LIN_W'(c2nv_s1);
			lin4_s2 <= (LIN_W'(c1nv_s1) <<< 1) + LIN_W'(c2nu_s1);
			q0n_s2  <= CNN_W'(c0nu_s1) * CNN_W'(nu_s1);
			q1n_s2  <= CNN_W'(c1nv_s1) * CNN_W'(nv_s1);
			q2n_s2  <= CNN_W'(c2nu_s1) * CNN_W'(nv_s1);
			q0l_s2  <= CNN_W'(c0lu_s1) * CNN_W'(light_u_q);
			q1l_s2  <= CNN_W'(c1lv_s1) * CNN_W'(light_v_q);
			q2l_s2  <= CNN_W'(c2lu_s1) * CNN_W'(light_v_q);
		end
		if (adv[3]) begin
			op_s3  <= op_s2;
			red_s3 <= red_s2;
			grn_s3 <= grn_s2;
			blu_s3 <= blu_s2;
			c3_s3  <= c3_s2;
			c4_s3  <= c4_s2;
			c5_s3  <= c5_s2;
			nu_s3  <= nu_s2;
			nv_s3  <= nv_s2;
			kl3_s3 <= KL_W'(k_q) * KL_W'(lin3_s2);
			kl4_s3 <= KL_W'(k_q) * KL_W'(lin4_s2);
			s5_s3  <= qsn[QS_W-1:FB];
			ql_s3  <= qsl[QS_W-1:FB];
		end
		if (adv[4]) begin
			op_s4  <= op_s3;
			red_s4 <= red_s3;
			grn_s4 <= grn_s3;
			blu_s4 <= blu_s3;
			c5_s4  <= c5_s3;
			nu_s4  <= nu_s3;
			nv_s4  <= nv_s3;
			a3_s4  <= A_W'(kl3_sh) + (A_W'(c3_s3) <<< FB);
			a4_s4  <= A_W'(kl4_sh) + (A_W'(c4_s3) <<< FB);
			// The shifted coefficient cancels, leaving the negated gain term.
			d3_s4  <= -D_W'(kl3_sh);
			d4_s4  <= -D_W'(kl4_sh);
			ks5_s4 <= KS_W'(k_q) * KS_W'(s5_s3);
			qg_s4  <= QG_W'(ql_s3) * QG_W'(gain_s);
		end
		if (adv[5]) begin
			op_s5  <= op_s4;
			red_s5 <= red_s4;
			grn_s5 <= grn_s4;
			blu_s5 <= blu_s4;
			c5_s5  <= c5_s4;
			ks5_s5 <= ks5_s4;
			qg_s5  <= qg_s4;
			d3n_s5 <= DN_W'(d3_s4) * DN_W'(nu_s4);
			d4n_s5 <= DN_W'(d4_s4) * DN_W'(nv_s4);
			a3l_s5 <= AL_W'(a3_s4) * AL_W'(light_u_q);
			a4l_s5 <= AL_W'(a4_s4) * AL_W'(light_v_q);
		end
		if (adv[6]) begin
			op_s6  <= op_s5;
			red_s6 <= red_s5;
			grn_s6 <= grn_s5;
			blu_s6 <= blu_s5;
			a5_s6  <= A5_W'(ks5_sh) + A5_W'(d3n_sh) + A5_W'(d4n_sh) + (A5_W'(c5_s5) <<< FB);
			p_s6   <= P_W'(qg_sh) + P_W'(a3l_sh) + P_W'(a4l_sh);
		end
		if (adv[7]) begin
			op_s7  <= op_s6;
			red_s7 <= red_s6;
			grn_s7 <= grn_s6;
			blu_s7 <= blu_s6;
			t_s7   <= T_W'(a5_s6) + T_W'(p_s6);
		end
		if (adv[8]) begin
			op_s8 <= op_s7;
			ch_s8 <= sat_byte(XT_W'(t_sh));
			xr_s8 <= XT_W'($signed({1'b0, red_s7})) * XT_W'(t_s7);
			xg_s8 <= XT_W'($signed({1'b0, grn_s7})) * XT_W'(t_s7);
			xb_s8 <= XT_W'($signed({1'b0, blu_s7})) * XT_W'(t_s7);
		end
		if (adv[9]) begin
			if (op_s8 == ptmdg_pkg::OP_LUMINANCE) begin
				red_s9 <= sat_byte(XT_W'(xr_sh));
				grn_s9 <= sat_byte(XT_W'(xg_sh));
				blu_s9 <= sat_byte(XT_W'(xb_sh));
			end else begin
				red_s9 <= ch_s8;
				grn_s9 <= '0;
				blu_s9 <= '0;
			end
		end
	end

	assign out_red   = red_s9;
	assign out_green = grn_s9;
	assign out_blue  = blu_s9;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_q))
		else $error("input stalled while the pipeline has a free stage");

	a_flow_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled although the output is draining");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[1] && !adv[2]) |=> (vld_q[1] && $stable(c0nu_s1)))
		else $error("first stage lost or changed a held request");

	a_gain_complement: assert property (@(posedge clk) disable iff (!arst_n)
		k_q == (K_W'(ptmdg_pkg::GAIN_ONE) - K_W'(gain_s)))
		else $error("gain complement out of step with the gain register");
`endif

endmodule

>>> verif/ptmdg_checker.sv
`timescale 1ns / 1ps

module ptmdg_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [ptmdg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ptmdg_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                   in_valid,
	input  logic                                   in_stall,
	input  logic                                   opcode,
	input  logic signed [ptmdg_pkg::COEF_BITS-1:0] coef_0,
	input  logic signed [ptmdg_pkg::COEF_BITS-1:0] coef_1,
	input  logic signed [ptmdg_pkg::COEF_BITS-1:0] coef_2,
	input  logic signed [ptmdg_pkg::COEF_BITS-1:0] coef_3,
	input  logic signed [ptmdg_pkg::COEF_BITS-1:0] coef_4,
	input  logic signed [ptmdg_pkg::COEF_BITS-1:0] coef_5,
	input  logic signed [ptmdg_pkg::DIR_BITS-1:0]  normal_u,
	input  logic signed [ptmdg_pkg::DIR_BITS-1:0]  normal_v,
	input  logic [ptmdg_pkg::BYTE_BITS-1:0]        red_in,
	input  logic [ptmdg_pkg::BYTE_BITS-1:0]        green_in,
	input  logic [ptmdg_pkg::BYTE_BITS-1:0]        blue_in,
	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic [ptmdg_pkg::BYTE_BITS-1:0]        out_red,
	input  logic [ptmdg_pkg::BYTE_BITS-1:0]        out_green,
	input  logic [ptmdg_pkg::BYTE_BITS-1:0]        out_blue,
	output int                                     shade_errors,
	output int                                     shades_in_flight
);
	import ptmdg_pkg::*;

	typedef struct packed {
		logic [BYTE_BITS-1:0] red;
		logic [BYTE_BITS-1:0] green;
		logic [BYTE_BITS-1:0] blue;
	} shaded_px_t;

	shaded_px_t                  expected_shades[$];
	shaded_px_t                  want;
	logic [GAIN_BITS-1:0]        gain_reg;
	logic signed [DIR_BITS-1:0]  light_u_reg;
	logic signed [DIR_BITS-1:0]  light_v_reg;
	int                          results_seen;

	initial begin
		shade_errors = 0;
		results_seen = 0;
	end

	function automatic logic [BYTE_BITS-1:0] clamp_byte(input logic signed [63:0] v);
		if (v < 0)
			return '0;
		if (v > BYTE_MAX)
			return BYTE_BITS'(BYTE_MAX);
		return v[BYTE_BITS-1:0];
	endfunction

	// Diffuse gain rewrite about the normal, then evaluation at the light.
	// All arithmetic is 64-bit two's complement and wraps like the hardware spec.
	function automatic shaded_px_t shade_pixel(
		input logic                          op,
		input logic signed [COEF_BITS-1:0]   r0, r1, r2, r3, r4, r5,
		input logic signed [DIR_BITS-1:0]    nu16, nv16,
		input logic [BYTE_BITS-1:0]          red, green, blue
	);
		logic signed [63:0] c0, c1, c2, c3, c4, c5, nu, nv, lu, lv, g, k;
		logic signed [63:0] c3f, c4f, a3, a4, s5, a5, q, t;
		shaded_px_t px;
		c0 = r0;
		c1 = r1;
		c2 = r2;
		c3 = r3;
		c4 = r4;
		c5 = r5;
		nu = nu16;
		nv = nv16;
		lu = light_u_reg;
		lv = light_v_reg;
		g = $signed({48'd0, gain_reg});
		k = GAIN_ONE - g;
		c3f = c3 <<< FRAC_BITS;
		c4f = c4 <<< FRAC_BITS;
		a3 = ((k * (64'sd2 * c0 * nu + c2 * nv)) >>> GAIN_FRAC) + c3f;
		a4 = ((k * (64'sd2 * c1 * nv + c2 * nu)) >>> GAIN_FRAC) + c4f;
		s5 = (c0 * nu * nu + c1 * nv * nv + c2 * nu * nv) >>> FRAC_BITS;
		a5 = ((k * s5) >>> GAIN_FRAC) + (((c3f - a3) * nu) >>> FRAC_BITS)
			+ (((c4f - a4) * nv) >>> FRAC_BITS) + (c5 <<< FRAC_BITS);
		q = (((c0 * lu * lu + c1 * lv * lv + c2 * lu * lv) >>> FRAC_BITS) * g) >>> GAIN_FRAC;
		t = q + ((a3 * lu) >>> FRAC_BITS) + ((a4 * lv) >>> FRAC_BITS) + a5;
		if (op == OP_CHANNEL) begin
			px.red = clamp_byte(t >>> FRAC_BITS);
			px.green = '0;
			px.blue = '0;
		end else begin
			px.red = clamp_byte(($signed({56'd0, red}) * t) >>> (FRAC_BITS + BYTE_BITS));
			px.green = clamp_byte(($signed({56'd0, green}) * t) >>> (FRAC_BITS + BYTE_BITS));
			px.blue = clamp_byte(($signed({56'd0, blue}) * t) >>> (FRAC_BITS + BYTE_BITS));
		end
		return px;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		if (shade_errors < 40)
			$display("mismatch on result %0d: %s is %0d, predicted %0d",
				results_seen, what, got, exp_val);
		shade_errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_shades.delete();
			gain_reg = GAIN_RESET;
			light_u_reg = '0;
			light_v_reg = '0;
			shades_in_flight = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GAIN:    gain_reg = cfg_data;
					REG_LIGHT_U: light_u_reg = cfg_data;
					REG_LIGHT_V: light_v_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_shades.push_back(shade_pixel(opcode, coef_0, coef_1, coef_2, coef_3,
					coef_4, coef_5, normal_u, normal_v, red_in, green_in, blue_in));
			if (out_valid && !out_stall) begin
				if (expected_shades.size() == 0) begin
					report_mismatch("unrequested result, red", out_red, -1);
				end else begin
					want = expected_shades.pop_front();
					if (out_red !== want.red)
						report_mismatch("out_red", out_red, want.red);
					if (out_green !== want.green)
						report_mismatch("out_green", out_green, want.green);
					if (out_blue !== want.blue)
						report_mismatch("out_blue", out_blue, want.blue);
				end
				results_seen++;
			end
			shades_in_flight = expected_shades.size();
		end
	end

endmodule

>>> verif/tb_ptm_diffuse_gain_shade.sv
`timescale 1ns / 1ps

module tb_ptm_diffuse_gain_shade;
	import ptmdg_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic                        op;
		logic signed [COEF_BITS-1:0] c0;
		logic signed [COEF_BITS-1:0] c1;
		logic signed [COEF_BITS-1:0] c2;
		logic signed [COEF_BITS-1:0] c3;
		logic signed [COEF_BITS-1:0] c4;
		logic signed [COEF_BITS-1:0] c5;
		logic signed [DIR_BITS-1:0]  nu;
		logic signed [DIR_BITS-1:0]  nv;
		logic [BYTE_BITS-1:0]        red;
		logic [BYTE_BITS-1:0]        green;
		logic [BYTE_BITS-1:0]        blue;
	} pixel_req_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic                        opcode = OP_CHANNEL;
	logic signed [COEF_BITS-1:0] coef_0 = '0;
	logic signed [COEF_BITS-1:0] coef_1 = '0;
	logic signed [COEF_BITS-1:0] coef_2 = '0;
	logic signed [COEF_BITS-1:0] coef_3 = '0;
	logic signed [COEF_BITS-1:0] coef_4 = '0;
	logic signed [COEF_BITS-1:0] coef_5 = '0;
	logic signed [DIR_BITS-1:0]  normal_u = '0;
	logic signed [DIR_BITS-1:0]  normal_v = '0;
	logic [BYTE_BITS-1:0]        red_in = '0;
	logic [BYTE_BITS-1:0]        green_in = '0;
	logic [BYTE_BITS-1:0]        blue_in = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [BYTE_BITS-1:0]        out_red;
	logic [BYTE_BITS-1:0]        out_green;
	logic [BYTE_BITS-1:0]        out_blue;

	int   shade_errors;
	int   shades_in_flight;
	int   idle_pct = 0;
	int   stall_pct = 0;
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;
	int   cycle_count = 0;

	ptm_diffuse_gain_shade u_dut (.*);

	ptmdg_checker u_check (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// The one long hold-off lets the pipeline fill so the input side must stall.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic pixel_req_t make_pixel(
		input logic                        op,
		input logic signed [COEF_BITS-1:0] c0, c1, c2, c3, c4, c5,
		input logic signed [DIR_BITS-1:0]  nu, nv,
		input logic [BYTE_BITS-1:0]        red, green, blue
	);
		pixel_req_t p;
		p.op = op;
		p.c0 = c0;
		p.c1 = c1;
		p.c2 = c2;
		p.c3 = c3;
		p.c4 = c4;
		p.c5 = c5;
		p.nu = nu;
		p.nv = nv;
		p.red = red;
		p.green = green;
		p.blue = blue;
		return p;
	endfunction

	// Mostly plausible pixels with normal components in [-1.0, 1.0] and modest coefficients, the rest raw bits.
	function automatic pixel_req_t random_pixel();
		pixel_req_t p;
		p.op = ($urandom_range(1) == 0) ? OP_CHANNEL : OP_LUMINANCE;
		p.red = $urandom_range(255);
		p.green = $urandom_range(255);
		p.blue = $urandom_range(255);
		if ($urandom_range(99) < 65) begin
			p.c0 = $urandom_range(255) - 128;
			p.c1 = $urandom_range(255) - 128;
			p.c2 = $urandom_range(255) - 128;
			p.c3 = $urandom_range(255) - 128;
			p.c4 = $urandom_range(255) - 128;
			p.c5 = $urandom_range(511) - 128;
			p.nu = $urandom_range(32768) - 16384;
			p.nv = $urandom_range(32768) - 16384;
		end else begin
			p.c0 = $urandom();
			p.c1 = $urandom();
			p.c2 = $urandom();
			p.c3 = $urandom();
			p.c4 = $urandom();
			p.c5 = $urandom();
			p.nu = $urandom();
			p.nv = $urandom();
		end
		return p;
	endfunction

	task automatic offer_pixel(input pixel_req_t p);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= p.op;
		coef_0 <= p.c0;
		coef_1 <= p.c1;
		coef_2 <= p.c2;
		coef_3 <= p.c3;
		coef_4 <= p.c4;
		coef_5 <= p.c5;
		normal_u <= p.nu;
		normal_v <= p.nv;
		red_in <= p.red;
		green_in <= p.green;
		blue_in <= p.blue;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic run_phase(
		input logic [CFG_DATA_W-1:0] gain,
		input logic [CFG_DATA_W-1:0] lu,
		input logic [CFG_DATA_W-1:0] lv,
		input logic                  stray,
		input int                    idle,
		input int                    stall,
		input logic                  hold,
		input int                    count
	);
		int i;
		@(negedge clk);
		while (shades_in_flight != 0)
			@(negedge clk);
		repeat (PIPE_STAGES + 2) @(posedge clk);
		write_reg(REG_GAIN, gain);
		write_reg(REG_LIGHT_U, lu);
		write_reg(REG_LIGHT_V, lv);
		if (stray)
			write_reg(REG_UNUSED, 16'hFFFF);
		cfg_valid <= 1'b0;
		idle_pct = idle;
		stall_pct <= stall;
		hold_go <= hold;
		for (i = 0; i < count; i++)
			offer_pixel(random_pixel());
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_pixel(make_pixel(OP_CHANNEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		offer_pixel(make_pixel(OP_CHANNEL, 0, 0, 0, 0, 0, 255, 0, 0, 0, 0, 0));
		offer_pixel(make_pixel(OP_CHANNEL, 0, 0, 0, 0, 0, 256, 0, 0, 0, 0, 0));
		offer_pixel(make_pixel(OP_CHANNEL, 0, 0, 0, 0, 0, -1, 0, 0, 0, 0, 0));
		offer_pixel(make_pixel(OP_CHANNEL, 0, 0, 0, 0, 0, 32767, 0, 0, 0, 0, 0));
		offer_pixel(make_pixel(OP_CHANNEL, 0, 0, 0, 0, 0, -32768, 0, 0, 0, 0, 0));
		offer_pixel(make_pixel(OP_CHANNEL, 32767, 32767, 32767, 32767, 32767, 32767,
			16384, 16384, 255, 255, 255));
		offer_pixel(make_pixel(OP_CHANNEL, -32768, -32768, -32768, -32768, -32768, -32768,
			-16384, -16384, 0, 0, 0));
		offer_pixel(make_pixel(OP_CHANNEL, 32767, 32767, 32767, 32767, 32767, 32767,
			-32768, 32767, 0, 0, 0));
		offer_pixel(make_pixel(OP_CHANNEL, 100, 100, 50, -50, -50, 128, 8192, -8192, 0, 0, 0));
		offer_pixel(make_pixel(OP_CHANNEL, 100, 100, 50, -50, -50, 128, 16384, 0, 0, 0, 0));
		offer_pixel(make_pixel(OP_LUMINANCE, 0, 0, 0, 0, 0, 0, 0, 0, 255, 255, 255));
		offer_pixel(make_pixel(OP_LUMINANCE, 0, 0, 0, 0, 0, 256, 0, 0, 255, 0, 128));
		offer_pixel(make_pixel(OP_LUMINANCE, 0, 0, 0, 0, 0, 255, 0, 0, 255, 255, 255));
		offer_pixel(make_pixel(OP_LUMINANCE, 0, 0, 0, 0, 0, 511, 0, 0, 255, 128, 1));
		offer_pixel(make_pixel(OP_LUMINANCE, 0, 0, 0, 0, 0, -1, 0, 0, 255, 255, 255));
		offer_pixel(make_pixel(OP_LUMINANCE, 32767, 32767, 32767, 32767, 32767, 32767,
			16384, 16384, 255, 255, 255));
		offer_pixel(make_pixel(OP_LUMINANCE, -32768, -32768, -32768, -32768, -32768, -32768,
			-16384, -16384, 255, 170, 85));
		offer_pixel(make_pixel(OP_LUMINANCE, 100, 100, 50, -50, -50, 128, 8192, -8192,
			200, 100, 50));
		offer_pixel(make_pixel(OP_LUMINANCE, 0, 0, 0, 0, 0, 32767, 0, 0, 1, 2, 3));
		in_valid <= 1'b0;

		run_phase(16'd4096, 16'h4000, 16'hC000, 1'b0, 0, 0, 1'b0, 250);
		run_phase(16'd40960, 16'hC000, 16'h4000, 1'b0, 81, 0, 1'b0, 250);
		run_phase($urandom_range(40960, 4096), $urandom_range(32768) - 16384,
			$urandom_range(32768) - 16384, 1'b0, 0, 81, 1'b0, 250);
		run_phase(16'd0, 16'h8000, 16'h7FFF, 1'b1, 16, 16, 1'b0, 250);
		run_phase(16'hFFFF, $urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
			1'b0, 0, 0, 1'b1, 300);
		run_phase($urandom_range(40960, 4096), 16'd0, 16'd0, 1'b0, 81, 81, 1'b0, 150);
		run_phase(16'd8192, $urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
			1'b0, 0, 0, 1'b0, 150);

		@(negedge clk);
		while (shades_in_flight != 0)
			@(negedge clk);
		repeat (PIPE_STAGES + 4) @(posedge clk);
		if (shade_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
